### hw/rtl/bbpt_pkg.sv
// shared types and constants of the beat and bar position tracker
// no dependencies
package bbpt_pkg;

  localparam int unsigned MarkerDepthDef = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegHasTrack = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffset   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPeriod   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBpb      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNearWin  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEnables  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMarkCnt  = 3'd6;

  // input ops
  localparam logic [1:0] OpTime    = 2'd0;
  localparam logic [1:0] OpMarker  = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;
  localparam logic [1:0] OpNop     = 2'd3;

  // result kinds
  localparam logic [1:0] KindPos    = 2'd0;
  localparam logic [1:0] KindMarker = 2'd1;
  localparam logic [1:0] KindIdle   = 2'd2;
  localparam logic [1:0] KindPreRoll = 2'd3;

  // divider request and status
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

### hw/rtl/bbpt_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on bbpt_pkg
module bbpt_div import bbpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0] quot_q, quot_d, dsr_q, dsr_d;
  logic [32:0] rem_q, rem_d, trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  assign trial = {rem_q[31:0], quot_q[31]} - {1'b0, dsr_q};

  // shift and subtract step
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d  = trial;
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[31:0];

endmodule

### hw/rtl/beat_bar_position_tracker_unit.sv
// beat and bar position tracker: a time update at or past the offset with a
// track runs two passes of the shared divider (beat period, then beats per bar),
// a multiply step and a position result, then one result per marker that fires; other words finish in idle.
// one word in flight at a time, next word taken once the last result leaves.
// async active-low reset restores register defaults and clears tracking;
// the marker table is not cleared.
module beat_bar_position_tracker_unit import bbpt_pkg::*; #(
  parameter int unsigned MarkerDepth = MarkerDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [31:0]         time_us_i,
  input  logic [3:0]          marker_slot_i,
  input  logic [31:0]         marker_time_us_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [31:0]         bar_number_o,
  output logic [3:0]          beat_in_bar_o,
  output logic [31:0]         time_into_beat_us_o,
  output logic                beat_event_o,
  output logic                bar_event_o,
  output logic                near_beat_o,
  output logic [31:0]         to_next_beat_us_o,
  output logic [31:0]         to_next_bar_us_o,
  output logic [3:0]          marker_fired_o,
  output logic                last_o
);

  localparam int unsigned MIdxW = (MarkerDepth > 1) ? $clog2(MarkerDepth) : 1;
  localparam int unsigned MCntW = $clog2(MarkerDepth + 1);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv1  = 6'b000010,
    StDiv2  = 6'b000100,
    StMul   = 6'b001000,
    StPos   = 6'b010000,
    StMark  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic        has_track_q;
  logic [31:0] offset_q, period_q;
  logic [4:0]  bpb_q, mcount_q;
  logic [19:0] near_q;
  logic [2:0]  en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_track_q <= 1'b0;
      offset_q    <= '0;
      period_q    <= 32'd500000;
      bpb_q       <= 5'd4;
      near_q      <= '0;
      en_q        <= 3'd7;
      mcount_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHasTrack: has_track_q <= cfg_data_i[0];
        RegOffset:   offset_q    <= cfg_data_i;
        RegPeriod:   period_q    <= cfg_data_i;
        RegBpb:      bpb_q       <= cfg_data_i[4:0];
        RegNearWin:  near_q      <= cfg_data_i[19:0];
        RegEnables:  en_q        <= cfg_data_i[2:0];
        RegMarkCnt:  mcount_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // clamped period and beats per bar
  logic [31:0] period;
  logic [4:0]  bpb;
  assign period = (period_q == '0) ? 32'd1 : period_q;
  always_comb begin
    bpb = bpb_q;
    if (bpb_q == 5'd0) bpb = 5'd1;
    else if (bpb_q > 5'd16) bpb = 5'd16;
  end

  logic [MCntW-1:0] limit;
  assign limit = ({{(MCntW > 5 ? MCntW-5 : 1){1'b0}}, mcount_q} > MarkerDepth)
                 ? MCntW'(MarkerDepth) : MCntW'(mcount_q);

  // marker table
  logic [31:0] mtab [MarkerDepth];
  logic [31:0] mrd_q;
  logic [MCntW-1:0] next_q, next_d;
  logic [8:0]  slot_ext;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;
  assign slot_ext = {5'd0, marker_slot_i};

  always_ff @(posedge clk_i) begin
    if (in_acc && op_i == OpMarker && slot_ext < 9'(MarkerDepth))
      mtab[slot_ext[MIdxW-1:0]] <= marker_time_us_i;
    mrd_q <= mtab[next_d[MIdxW-1:0]];
  end

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  bbpt_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // tracking state and working registers
  logic [31:0] rbar_q, rbar_d, ebar_q, ebar_d;
  logic [3:0]  rbeat_q, rbeat_d;
  logic        rval_q, rval_d, eval_q, eval_d;
  logic [31:0] t_q, t_d, into_q, into_d, tobar_q, tobar_d;
  logic [36:0] prod_q, prod_d;

  // output register
  logic        ov_q, ov_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] bar_q, bar_d, oint_q, oint_d, onb_q, onb_d, onr_q, onr_d;
  logic [3:0]  beat_q, beat_d, mf_q, mf_d;
  logic        bev_q, bev_d, brv_q, brv_d, near_q2, near_d, last_q, last_d;

  logic out_free;
  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;

  logic [31:0] to_beat;
  logic [36:0] pre_bar;
  logic        mfire;
  assign to_beat = period - into_q;
  assign pre_bar = 37'(period) * 37'(bpb);
  // marker at next_q fires; mrd_q holds entry next_q
  assign mfire = en_q[2] && (next_q < limit) && (mrd_q <= t_q);

  always_comb begin
    state_d = state_q;
    next_d = next_q;
    rbar_d = rbar_q; rbeat_d = rbeat_q; rval_d = rval_q;
    ebar_d = ebar_q; eval_d = eval_q;
    t_d = t_q; into_d = into_q; tobar_d = tobar_q; prod_d = prod_q;
    dreq = '0;
    ov_d = ov_q && !out_ready_i;
    kind_d = kind_q; bar_d = bar_q; beat_d = beat_q; oint_d = oint_q;
    bev_d = bev_q; brv_d = brv_q; near_d = near_q2; onb_d = onb_q;
    onr_d = onr_q; mf_d = mf_q; last_d = last_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (op_i == OpRestart) begin
            rbar_d = '0; rbeat_d = '0; rval_d = 1'b0;
            ebar_d = '0; eval_d = 1'b0; next_d = '0;
          end else if (op_i == OpTime) begin
            t_d = time_us_i;
            ov_d = 1'b1;
            {bar_d, beat_d, oint_d, bev_d, brv_d, near_d, onb_d, onr_d, mf_d} = '0;
            last_d = 1'b1;
            if (!has_track_q) begin
              kind_d = KindIdle;
            end else if (time_us_i < offset_q) begin
              kind_d = KindPreRoll;
              near_d = near_q != '0;
              onb_d = period;
              onr_d = (pre_bar[36:32] != '0) ? '1 : pre_bar[31:0];
            end else begin
              ov_d = 1'b0;
              dreq.start = 1'b1;
              dreq.dividend = time_us_i - offset_q;
              dreq.divisor = period;
              state_d = StDiv1;
            end
          end
        end
      end
      StDiv1: begin
        if (drsp.done) begin
          into_d = drsp.rem;
          dreq.start = 1'b1;
          dreq.dividend = drsp.quot;
          dreq.divisor = {27'd0, bpb};
          state_d = StDiv2;
        end
      end
      StDiv2: begin
        if (drsp.done) begin
          bar_d = drsp.quot;
          beat_d = drsp.rem[3:0];
          prod_d = 37'(5'(bpb - drsp.rem[4:0] - 5'd1)) * 37'(period);
          state_d = StMul;
        end
      end
      StMul: begin
        tobar_d = (prod_q + 37'(to_beat) > 37'h0FFFFFFFF) ? '1
                  : 32'(prod_q + 37'(to_beat));
        state_d = StPos;
      end
      StPos: begin
        if (out_free) begin
          ov_d = 1'b1;
          kind_d = KindPos;
          oint_d = into_q;
          onb_d = to_beat;
          onr_d = tobar_q;
          mf_d = '0;
          near_d = (into_q < 32'(near_q)) || (to_beat < 32'(near_q));
          bev_d = 1'b0; brv_d = 1'b0;
          if (en_q[0] && (!rval_q || bar_q != rbar_q || beat_q != rbeat_q)) begin
            bev_d = 1'b1; rbar_d = bar_q; rbeat_d = beat_q; rval_d = 1'b1;
          end
          if (en_q[1] && beat_q == '0 && (!eval_q || bar_q != ebar_q)) begin
            brv_d = 1'b1; ebar_d = bar_q; eval_d = 1'b1;
          end
          // look ahead one marker so that last lands on the final word
          last_d = !mfire;
          state_d = StIdle;
          if (mfire) begin
            next_d = next_q + MCntW'(1);
            state_d = StMark;
          end
        end
      end
      StMark: begin
        // marker next_q - 1 is due; mrd_q holds entry next_q
        if (out_free) begin
          ov_d = 1'b1;
          kind_d = KindMarker;
          {bar_d, beat_d, oint_d, bev_d, brv_d, near_d, onb_d, onr_d} = '0;
          mf_d = 4'(next_q - MCntW'(1));
          last_d = !mfire;
          state_d = StIdle;
          if (mfire) begin
            next_d = next_q + MCntW'(1);
            state_d = StMark;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      next_q <= '0;
      rbar_q <= '0; rbeat_q <= '0; rval_q <= 1'b0;
      ebar_q <= '0; eval_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      next_q <= next_d;
      rbar_q <= rbar_d; rbeat_q <= rbeat_d; rval_q <= rval_d;
      ebar_q <= ebar_d; eval_q <= eval_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; into_q <= into_d; tobar_q <= tobar_d; prod_q <= prod_d;
    kind_q <= kind_d; bar_q <= bar_d; beat_q <= beat_d; oint_q <= oint_d;
    bev_q <= bev_d; brv_q <= brv_d; near_q2 <= near_d; onb_q <= onb_d;
    onr_q <= onr_d; mf_q <= mf_d; last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign kind_o = kind_q;
  assign bar_number_o = bar_q;
  assign beat_in_bar_o = beat_q;
  assign time_into_beat_us_o = oint_q;
  assign beat_event_o = bev_q;
  assign bar_event_o = brv_q;
  assign near_beat_o = near_q2;
  assign to_next_beat_us_o = onb_q;
  assign to_next_bar_us_o = onr_q;
  assign marker_fired_o = mf_q;
  assign last_o = last_q;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_marker_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= MCntW'(MarkerDepth)) else $error("marker index past depth");
  a_ev_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (beat_event_o || bar_event_o) |-> kind_o == KindPos)
    else $error("event on non-position word");
`endif

endmodule

### tb/tb_top.sv
// testbench of the beat and bar position tracker: directed and random words,
// predicted results checked in order; depends on bbpt_pkg and the tracker rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bbpt_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bar;
    logic [3:0]  beat;
    logic [31:0] into;
    logic        beat_ev;
    logic        bar_ev;
    logic        near;
    logic [31:0] to_beat;
    logic [31:0] to_bar;
    logic [3:0]  marker;
    logic        last;
  } pos_res_t;

  // position predictor with its own register and tracking copy
  class position_board;
    bit [31:0] has_track, offset, period, bpb, near_win, enables, mark_cnt;
    bit [31:0] rep_bar, rep_beat, bar_ev_bar, next_mark;
    bit        rep_valid, bar_ev_valid;
    bit [31:0] mark_time [Depth];
    pos_res_t  pending [$];
    int        errors;
    int        checked;

    function void clear_tracking();
      rep_bar = 0; rep_beat = 0; rep_valid = 0;
      bar_ev_bar = 0; bar_ev_valid = 0; next_mark = 0;
    endfunction

    function void reset_regs();
      has_track = 0; offset = 0; period = 500000; bpb = 4;
      near_win = 0; enables = 7; mark_cnt = 0;
      clear_tracking();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, bit [31:0] v);
      case (idx)
        RegHasTrack: has_track = v & 1;
        RegOffset:   offset = v;
        RegPeriod:   period = v;
        RegBpb:      bpb = v & 32'h1f;
        RegNearWin:  near_win = v & 32'hfffff;
        RegEnables:  enables = v & 7;
        RegMarkCnt:  mark_cnt = v & 32'h1f;
        default: ;
      endcase
    endfunction

    // note an accepted word and queue its results
    function void note_word(logic [1:0] op, bit [31:0] t, bit [3:0] slot, bit [31:0] mt);
      bit [31:0] per, bb, adj, total, into, bar, beat, to_beat, lim;
      bit [63:0] to_bar;
      pos_res_t r;
      per = (period == 0) ? 1 : period;
      bb = (bpb == 0) ? 1 : (bpb > 16 ? 16 : bpb);
      if (op == OpMarker) begin
        mark_time[slot] = mt;
        return;
      end
      if (op == OpRestart) begin
        clear_tracking();
        return;
      end
      if (op != OpTime) return;
      r = '0;
      r.last = 1;
      if (!has_track) begin
        r.kind = KindIdle;
        pending.push_back(r);
        return;
      end
      if (t < offset) begin
        r.kind = KindPreRoll;
        r.near = near_win != 0;
        r.to_beat = per;
        to_bar = 64'(per) * bb;
        r.to_bar = to_bar > 64'hffffffff ? 32'hffffffff : to_bar[31:0];
        pending.push_back(r);
        return;
      end
      adj = t - offset;
      total = adj / per;
      into = adj % per;
      bar = total / bb;
      beat = total % bb;
      to_beat = per - into;
      to_bar = 64'(to_beat) + 64'(bb - beat - 1) * per;
      r.kind = KindPos;
      if (enables[0] && (!rep_valid || bar != rep_bar || beat != rep_beat)) begin
        r.beat_ev = 1;
        rep_bar = bar; rep_beat = beat; rep_valid = 1;
      end
      if (enables[1] && beat == 0 && (!bar_ev_valid || bar != bar_ev_bar)) begin
        r.bar_ev = 1;
        bar_ev_bar = bar; bar_ev_valid = 1;
      end
      r.bar = bar;
      r.beat = beat[3:0];
      r.into = into;
      r.near = (into < near_win) || (to_beat < near_win);
      r.to_beat = to_beat;
      r.to_bar = to_bar > 64'hffffffff ? 32'hffffffff : to_bar[31:0];
      r.last = 1;
      pending.push_back(r);
      if (enables[2]) begin
        lim = mark_cnt > Depth ? Depth : mark_cnt;
        while (next_mark < lim && mark_time[next_mark] <= t) begin
          pending[$].last = 0;
          r = '0;
          r.kind = KindMarker;
          r.marker = next_mark[3:0];
          r.last = 1;
          pending.push_back(r);
          next_mark++;
        end
      end
    endfunction

    // compare one result with the oldest expectation
    function void check_result(pos_res_t got);
      pos_res_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: actual %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t result mismatch: expected %p actual %p", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  logic [1:0] op_i = '0;
  logic [31:0] time_us_i = '0, marker_time_us_i = '0;
  logic [3:0] marker_slot_i = '0;
  logic out_valid_o, out_ready_i = 0;
  logic [1:0]  kind_o;
  logic [31:0] bar_number_o, time_into_beat_us_o, to_next_beat_us_o, to_next_bar_us_o;
  logic [3:0]  beat_in_bar_o, marker_fired_o;
  logic        beat_event_o, bar_event_o, near_beat_o, last_o;
  pos_res_t got;

  position_board board;
  int cycles = 0;
  bit calm = 0;
  bit hold_out = 0;
  bit [31:0] marks_set = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  beat_bar_position_tracker_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .time_us_i, .marker_slot_i, .marker_time_us_i,
    .out_valid_o, .out_ready_i,
    .kind_o, .bar_number_o, .beat_in_bar_o,
    .time_into_beat_us_o, .beat_event_o, .bar_event_o,
    .near_beat_o, .to_next_beat_us_o, .to_next_bar_us_o,
    .marker_fired_o, .last_o
  );

  assign got = {kind_o, bar_number_o, beat_in_bar_o, time_into_beat_us_o, beat_event_o,
                bar_event_o, near_beat_o, to_next_beat_us_o, to_next_bar_us_o,
                marker_fired_o, last_o};

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("beat_bar_position_tracker_unit verification failed");
      $finish;
    end
  end

  // result sampling
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(got);

  // receiver with random stall bursts and one long hold-off
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ready_i <= 0;
        repeat (400) @(negedge clk_i);
        hold_out = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        n = $urandom_range(1, 18);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, bit [31:0] v);
    @(negedge clk_i);
    in_valid_i <= 0;
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    board.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // send one word, with an optional random gap before it; returns at the
  // accepting edge, the following negedge replaces or drops the word
  task automatic send_word(logic [1:0] op, bit [31:0] t, bit [3:0] slot, bit [31:0] mt);
    int n;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      n = $urandom_range(1, 18);
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1; op_i <= op; time_us_i <= t;
    marker_slot_i <= slot; marker_time_us_i <= mt;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(op, t, slot, mt);
  endtask

  task automatic time_word(bit [31:0] t);
    send_word(OpTime, t, 4'($urandom), $urandom);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // random time near the current grid, sometimes anywhere
  function automatic bit [31:0] grid_time(bit [31:0] base);
    bit [63:0] v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    v = 64'(base) + 64'(board.period) * $urandom_range(0, 40) + $urandom_range(0, 3)
        - ($urandom_range(0, 1) ? 64'(board.near_win) : 0);
    return v[31:0];
  endfunction

  initial begin
    bit [31:0] t;
    int i;
    board = new();
    board.reset_regs();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // no track, then directed extremes
    time_word(32'h0);
    send_word(OpNop, $urandom, 4'($urandom), $urandom);
    for (i = 0; i < Depth; i++) begin
      send_word(OpMarker, 0, i[3:0], 32'd1000 * i);
      marks_set[i] = 1;
    end
    drain();
    write_reg(RegHasTrack, 1);
    write_reg(RegOffset, 1000);
    write_reg(RegPeriod, 250);
    write_reg(RegBpb, 4);
    write_reg(RegNearWin, 20);
    write_reg(RegEnables, 7);
    write_reg(RegMarkCnt, 17);
    time_word(999);
    time_word(1000);
    time_word(1005);
    time_word(1240);
    time_word(2000);
    time_word(32'hffffffff);
    send_word(OpRestart, 0, 0, 0);
    time_word(1000);
    drain();
    // zero period, zero bpb, saturating bar time
    write_reg(RegPeriod, 0);
    write_reg(RegBpb, 0);
    write_reg(RegNearWin, 20'hfffff);
    write_reg(RegOffset, 0);
    time_word(7);
    time_word(32'hffffffff);
    drain();
    write_reg(RegPeriod, 32'hffffffff);
    write_reg(RegBpb, 31);
    time_word(0);
    time_word(32'hfffffffe);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 5);
      write_reg(RegHasTrack, 32'(ph != 1));
      write_reg(RegOffset, $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom);
      write_reg(RegPeriod, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2000));
      write_reg(RegBpb, $urandom_range(0, 31));
      write_reg(RegNearWin, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1000000)
                                                       : $urandom_range(0, 300));
      write_reg(RegEnables, $urandom_range(0, 7));
      write_reg(RegMarkCnt, $urandom_range(0, 31));
      send_word(OpRestart, 0, 0, 0);
      if (ph == 2) hold_out = 1;
      for (i = 0; i < 15; i++) begin
        case ($urandom_range(0, 9))
          0: send_word(OpMarker, 0, 4'($urandom), grid_time(board.offset));
          1: send_word($urandom_range(0, 1) ? OpRestart : OpNop, $urandom, 4'($urandom),
                       $urandom);
          default: time_word(grid_time(board.offset));
        endcase
      end
      drain();
    end

    $display("covered idle, pre-roll, position and marker results over %0d results",
             board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("beat_bar_position_tracker_unit verification clean");
    end else begin
      $display("beat_bar_position_tracker_unit verification failed");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/bbpt_pkg.sv
hw/rtl/bbpt_div.sv
hw/rtl/beat_bar_position_tracker_unit.sv
tb/tb_top.sv
